/* rtl/core/mtd_pkg.sv */
`timescale 1ns / 1ps

package mtd_pkg;

    localparam int FACTOR_W       = 64;
    localparam int HALF_W         = FACTOR_W / 2;
    localparam int PROD_W         = 2 * FACTOR_W;
    localparam int DIV_W          = 32;
    localparam int QUOT_W         = 64;
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = PROD_W / BITS_PER_STAGE;
    localparam int MULT_STAGES    = 3;
    localparam int LATENCY        = MULT_STAGES + DIV_STAGES + 1;

    // running state of the long division; work starts as the dividend and
    // fills with quotient bits from the bottom as dividend bits leave the top
    typedef struct packed {
        logic [DIV_W-1:0]  rem;
        logic [PROD_W-1:0] work;
        logic [DIV_W-1:0]  divisor;
        logic              dz;
    } t_div_slot;

endpackage

/* rtl/core/mtd_mult.sv */
`timescale 1ns / 1ps

module mtd_mult
    import mtd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [FACTOR_W-1:0] i_factor_a,
    input  logic [FACTOR_W-1:0] i_factor_b,
    input  logic [DIV_W-1:0]    i_divisor_value,
    output logic                o_valid,
    output t_div_slot           o_slot
);

    // stage 1: partial products
    logic                r_v1;
    logic [FACTOR_W-1:0] r_p00, r_p01, r_p10, r_p11;
    logic [DIV_W-1:0]    r_d1;
    // stage 2: low half and middle carry
    logic                r_v2;
    logic [FACTOR_W-1:0] r_lo2;
    logic [1:0]          r_mid_c2;
    logic [FACTOR_W-1:0] r_p11_2;
    logic [HALF_W-1:0]   r_p01h2, r_p10h2;
    logic [DIV_W-1:0]    r_d2;
    // stage 3: full product
    logic                r_v3;
    t_div_slot           r_slot3;

    logic [HALF_W+1:0]   n_mid;
    logic [FACTOR_W-1:0] n_hi;

    assign n_mid = {2'b00, r_p00[FACTOR_W-1:HALF_W]}
                 + {2'b00, r_p01[HALF_W-1:0]}
                 + {2'b00, r_p10[HALF_W-1:0]};

    assign n_hi = r_p11_2
                + {{HALF_W{1'b0}}, r_p01h2}
                + {{HALF_W{1'b0}}, r_p10h2}
                + {{(FACTOR_W-2){1'b0}}, r_mid_c2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p00 <= i_factor_a[HALF_W-1:0]        * i_factor_b[HALF_W-1:0];
        r_p01 <= i_factor_a[HALF_W-1:0]        * i_factor_b[FACTOR_W-1:HALF_W];
        r_p10 <= i_factor_a[FACTOR_W-1:HALF_W] * i_factor_b[HALF_W-1:0];
        r_p11 <= i_factor_a[FACTOR_W-1:HALF_W] * i_factor_b[FACTOR_W-1:HALF_W];
        r_d1  <= i_divisor_value;

        r_lo2    <= {n_mid[HALF_W-1:0], r_p00[HALF_W-1:0]};
        r_mid_c2 <= n_mid[HALF_W+1:HALF_W];
        r_p11_2  <= r_p11;
        r_p01h2  <= r_p01[FACTOR_W-1:HALF_W];
        r_p10h2  <= r_p10[FACTOR_W-1:HALF_W];
        r_d2     <= r_d1;

        r_slot3.rem     <= '0;
        r_slot3.work    <= {n_hi, r_lo2};
        r_slot3.divisor <= r_d2;
        r_slot3.dz      <= (r_d2 == '0);
    end

    assign o_valid = r_v3;
    assign o_slot  = r_slot3;

endmodule

/* rtl/core/mtd_div_stage.sv */
`timescale 1ns / 1ps

module mtd_div_stage
    import mtd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_div_slot i_slot,
    output logic      o_valid,
    output t_div_slot o_slot
);

    logic      r_valid;
    t_div_slot r_slot;
    t_div_slot n_slot;
    logic [DIV_W:0] trial;

    // restoring division, BITS_PER_STAGE quotient bits per stage
    always_comb begin
        n_slot = i_slot;
        trial  = '0;
        for (int k = 0; k < BITS_PER_STAGE; k++) begin
            trial       = {n_slot.rem, n_slot.work[PROD_W-1]};
            n_slot.work = {n_slot.work[PROD_W-2:0], 1'b0};
            if (trial >= {1'b0, n_slot.divisor}) begin
                n_slot.rem     = DIV_W'(trial - {1'b0, n_slot.divisor});
                n_slot.work[0] = 1'b1;
            end else begin
                n_slot.rem = trial[DIV_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    assign o_valid = r_valid;
    assign o_slot  = r_slot;

endmodule

/* rtl/core/mtd_divider.sv */
`timescale 1ns / 1ps

module mtd_divider
    import mtd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_div_slot i_slot,
    output logic      o_valid,
    output t_div_slot o_slot
);

    logic      w_valid [DIV_STAGES+1];
    t_div_slot w_slot  [DIV_STAGES+1];

    assign w_valid[0] = i_valid;
    assign w_slot[0]  = i_slot;

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        mtd_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .i_slot  (w_slot[g]),
            .o_valid (w_valid[g+1]),
            .o_slot  (w_slot[g+1])
        );
    end

    assign o_valid = w_valid[DIV_STAGES];
    assign o_slot  = w_slot[DIV_STAGES];

endmodule

/* rtl/core/mul_then_div_64x64_by_32.sv */
`timescale 1ns / 1ps

// Multiplies two unsigned 64-bit factors into a 128-bit product and divides it
// by an unsigned 32-bit divisor, giving the low 64 bits of the quotient and the
// exact remainder. A zero divisor sets o_divide_by_zero with quotient and
// remainder zero. The block takes a transaction every cycle (busy is high only
// while reset is held) and presents each result with o_valid for one cycle,
// after 32x32 partial products and product assembly, restoring division at 2
// quotient bits per stage, and 1 output register. Results come out in order and
// cannot be stalled, so the receiver must take each one when o_valid is high.

module mul_then_div_64x64_by_32
    import mtd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [FACTOR_W-1:0] i_factor_a,
    input  logic [FACTOR_W-1:0] i_factor_b,
    input  logic [DIV_W-1:0]    i_divisor_value,
    output logic                o_valid,
    output logic [QUOT_W-1:0]   o_quotient_low,
    output logic [DIV_W-1:0]    o_remainder_value,
    output logic                o_divide_by_zero
);

    logic      accept;
    logic      mult_valid;
    t_div_slot mult_slot;
    logic      div_valid;
    t_div_slot div_slot;

    logic              r_valid;
    logic [QUOT_W-1:0] r_quotient_low;
    logic [DIV_W-1:0]  r_remainder_value;
    logic              r_divide_by_zero;

    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    mtd_mult u_mult (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (accept),
        .i_factor_a      (i_factor_a),
        .i_factor_b      (i_factor_b),
        .i_divisor_value (i_divisor_value),
        .o_valid         (mult_valid),
        .o_slot          (mult_slot)
    );

    mtd_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mult_valid),
        .i_slot  (mult_slot),
        .o_valid (div_valid),
        .o_slot  (div_slot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_slot.dz) begin
            r_quotient_low    <= '0;
            r_remainder_value <= '0;
        end else begin
            r_quotient_low    <= div_slot.work[QUOT_W-1:0];
            r_remainder_value <= div_slot.rem;
        end
        r_divide_by_zero <= div_slot.dz;
    end

    assign o_valid           = r_valid;
    assign o_quotient_low    = r_quotient_low;
    assign o_remainder_value = r_remainder_value;
    assign o_divide_by_zero  = r_divide_by_zero;

    a_result_has_start: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LATENCY)
    ) else $error("result without matching start");

    a_rem_below_divisor: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_divide_by_zero) |->
            (o_remainder_value < $past(i_divisor_value, LATENCY))
    ) else $error("remainder not below divisor");

    a_dz_zero_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_divide_by_zero) |->
            (o_quotient_low == '0 && o_remainder_value == '0)
    ) else $error("zero divisor result not cleared");

    a_dz_matches_input: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_divide_by_zero == ($past(i_divisor_value, LATENCY) == '0))
    ) else $error("divide by zero flag mismatch");

endmodule
